@@ hw/rtl/cdps_pkg.sv @@
// Package for the clock divider pair search unit: widths, limits, defaults
// and the sequencer state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cdps_pkg;

    localparam int unsigned MAX_DIV_A   = 127;
    localparam int unsigned NUM_OFFSETS = 4;

    localparam int unsigned FREQ_W = 24;
    localparam int unsigned VAL_W  = 16;
    localparam int unsigned A_W    = 7;
    localparam int unsigned DIV_CNT_W = $clog2(VAL_W);
    localparam int unsigned OFF_W  = (NUM_OFFSETS > 1) ? $clog2(NUM_OFFSETS) : 1;

    localparam logic [FREQ_W-1:0] NOMINAL_Q8  = 24'h800000;
    localparam logic [FREQ_W-1:0] ROUND_HALF  = 24'h000080;
    localparam logic [A_W-1:0]    DEFAULT_A   = 7'd127;
    localparam logic [VAL_W-1:0]  DEFAULT_S   = 16'd255;
    localparam logic [VAL_W-1:0]  NO_ERR_YET  = 16'hffff;
    localparam logic [A_W-1:0]    FIRST_A     = A_W'(MAX_DIV_A);
    localparam logic [A_W-1:0]    LAST_A      = 7'd2;
    localparam logic [OFF_W-1:0]  LAST_OFFSET = OFF_W'(NUM_OFFSETS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SETUP,
        ST_TRIAL,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/clock_divider_pair_search_unit.sv @@
// Top level of the clock divider pair search unit: a sequencer around one
// shared restoring divider and one add/compare unit. Depends on cdps_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// A command is a transfer of measured_freq_q8 (unsigned Q16.8 Hz) at a rising
// edge where start is high and busy is low. busy stays high until the result
// has been shown. The result div_a/div_s is valid for exactly one cycle while
// done is high; the receiver must take it then, as nothing holds it.
// The input is rounded to a 16-bit target T. For each A from 127 down to 2
// the shared divider produces T/A and T%A (one quotient bit per cycle), a
// setup step forms the first error 2A - T%A, and up to 4 trial offsets
// step the error down by A and compare it with the best so far.
// Each A runs a full division; the 126 values of A set the worst case.
// A search that hits an error of zero ends early; the nominal input
// 32768.0 skips the search and done rises in the cycle after the transfer.
// A new command can be given in the cycle after done.
// Reset (rst_n low, asynchronous) returns the sequencer to idle; any search
// in progress is dropped and no result is produced for it.
module clock_divider_pair_search_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [cdps_pkg::FREQ_W-1:0]   measured_freq_q8,
    output logic                               done,
    output logic [cdps_pkg::A_W-1:0]           div_a,
    output logic [cdps_pkg::VAL_W-1:0]         div_s
);

    cdps_pkg::state_t state_reg, state_next;

    logic [cdps_pkg::VAL_W-1:0]     target_reg, target_next;
    logic [cdps_pkg::A_W-1:0]       a_reg, a_next;
    logic [cdps_pkg::VAL_W-1:0]     dvd_reg, dvd_next;
    logic [cdps_pkg::A_W-1:0]       rem_reg, rem_next;
    logic [cdps_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [cdps_pkg::VAL_W-1:0]     err_reg, err_next;
    logic [cdps_pkg::VAL_W-1:0]     s_reg, s_next;
    logic [cdps_pkg::OFF_W-1:0]     k_reg, k_next;
    logic [cdps_pkg::VAL_W-1:0]     best_err_reg, best_err_next;
    logic [cdps_pkg::A_W-1:0]       best_a_reg, best_a_next;
    logic [cdps_pkg::VAL_W-1:0]     best_s_reg, best_s_next;

    logic                           accept;
    logic [cdps_pkg::FREQ_W-1:0]    rounded;
    logic [cdps_pkg::A_W:0]         part_rem;
    logic                           q_bit;
    logic [cdps_pkg::A_W:0]         part_diff;
    logic                           better;
    logic                           hit_zero;
    logic                           last_offset;
    logic                           last_a;
    logic                           div_last;

    assign accept   = start && (state_reg == cdps_pkg::ST_IDLE);
    assign rounded  = measured_freq_q8 + cdps_pkg::ROUND_HALF;

    // One step of restoring division: bring down the next dividend bit.
    assign part_rem  = {rem_reg, dvd_reg[cdps_pkg::VAL_W-1]};
    assign q_bit     = (part_rem >= {1'b0, a_reg});
    assign part_diff = part_rem - {1'b0, a_reg};

    assign better      = (err_reg < best_err_reg);
    assign hit_zero    = (err_reg == '0);
    assign last_offset = (k_reg == cdps_pkg::LAST_OFFSET);
    assign last_a      = (a_reg == cdps_pkg::LAST_A);
    assign div_last    = (cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cdps_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg   <= target_next;
        a_reg        <= a_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        err_reg      <= err_next;
        s_reg        <= s_next;
        k_reg        <= k_next;
        best_err_reg <= best_err_next;
        best_a_reg   <= best_a_next;
        best_s_reg   <= best_s_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cdps_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (measured_freq_q8 == cdps_pkg::NOMINAL_Q8)
                    begin
                        state_next = cdps_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = cdps_pkg::ST_DIV;
                    end
                end
            end
            cdps_pkg::ST_DIV:
            begin
                if (div_last)
                begin
                    state_next = cdps_pkg::ST_SETUP;
                end
            end
            cdps_pkg::ST_SETUP:
            begin
                state_next = cdps_pkg::ST_TRIAL;
            end
            cdps_pkg::ST_TRIAL:
            begin
                if (better && hit_zero)
                begin
                    state_next = cdps_pkg::ST_DONE;
                end
                else if (last_offset)
                begin
                    state_next = last_a ? cdps_pkg::ST_DONE : cdps_pkg::ST_DIV;
                end
            end
            cdps_pkg::ST_DONE:
            begin
                state_next = cdps_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = cdps_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath: shared divider and error stepper.
    always_comb
    begin
        target_next   = target_reg;
        a_next        = a_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        err_next      = err_reg;
        s_next        = s_reg;
        k_next        = k_reg;
        best_err_next = best_err_reg;
        best_a_next   = best_a_reg;
        best_s_next   = best_s_reg;

        unique case (state_reg)
            cdps_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    target_next   = rounded[cdps_pkg::VAL_W+7:8];
                    a_next        = cdps_pkg::FIRST_A;
                    dvd_next      = rounded[cdps_pkg::VAL_W+7:8];
                    rem_next      = '0;
                    cnt_next      = cdps_pkg::DIV_CNT_W'(cdps_pkg::VAL_W - 1);
                    best_err_next = cdps_pkg::NO_ERR_YET;
                    best_a_next   = cdps_pkg::DEFAULT_A;
                    best_s_next   = cdps_pkg::DEFAULT_S;
                end
            end
            cdps_pkg::ST_DIV:
            begin
                // The quotient bits shift into the dividend register.
                dvd_next = {dvd_reg[cdps_pkg::VAL_W-2:0], q_bit};
                rem_next = q_bit ? part_diff[cdps_pkg::A_W-1:0]
                                 : part_rem[cdps_pkg::A_W-1:0];
                cnt_next = cnt_reg - 1'b1;
            end
            cdps_pkg::ST_SETUP:
            begin
                // With T = A*Q + R, A*(Q+2) - T equals 2A - R.
                err_next = cdps_pkg::VAL_W'({a_reg, 1'b0})
                         - cdps_pkg::VAL_W'(rem_reg);
                s_next   = dvd_reg + 16'd2;
                k_next   = '0;
            end
            cdps_pkg::ST_TRIAL:
            begin
                if (better)
                begin
                    best_err_next = err_reg;
                    best_a_next   = a_reg;
                    best_s_next   = s_reg;
                end
                err_next = err_reg - cdps_pkg::VAL_W'(a_reg);
                s_next   = s_reg - 16'd1;
                k_next   = k_reg + 1'b1;
                if (last_offset && !(better && hit_zero) && !last_a)
                begin
                    a_next   = a_reg - 1'b1;
                    dvd_next = target_reg;
                    rem_next = '0;
                    cnt_next = cdps_pkg::DIV_CNT_W'(cdps_pkg::VAL_W - 1);
                end
            end
            cdps_pkg::ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        busy = (state_reg != cdps_pkg::ST_IDLE);
        done = (state_reg == cdps_pkg::ST_DONE);
    end

    assign div_a = best_a_reg;
    assign div_s = best_s_reg;

`ifndef SYNTHESIS
    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("done was not followed by an idle cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not make the unit busy");

    a_a_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cdps_pkg::ST_DIV || state_reg == cdps_pkg::ST_TRIAL)
        |-> (a_reg >= cdps_pkg::LAST_A && a_reg <= cdps_pkg::FIRST_A))
        else $error("divider A left its search range");

    a_rem_below_a: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cdps_pkg::ST_SETUP) |-> (rem_reg < a_reg))
        else $error("division remainder not below divisor");

    a_best_never_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg) == cdps_pkg::ST_TRIAL && state_reg != cdps_pkg::ST_IDLE)
        |-> (best_err_reg <= $past(best_err_reg)))
        else $error("best error increased during the search");
`endif

endmodule

`default_nettype wire
